/* hdl/drba_pkg.sv */
`default_nettype none

package drba_pkg;

  // Memory-map table capacity.
  localparam int MAX_ENTRIES = 64;
  localparam int IDX_W       = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);

  localparam int ADDR_W    = 64;
  localparam int TYPE_W    = 8;
  localparam int OPC_W     = 2;
  localparam int CFG_IDX_W = 3;

  // Input word layout, lowest bit first.
  localparam int IN_BASE_LSB  = 0;
  localparam int IN_LEN_LSB   = IN_BASE_LSB + ADDR_W;
  localparam int IN_TYPE_LSB  = IN_LEN_LSB + ADDR_W;
  localparam int IN_SIZE_LSB  = IN_TYPE_LSB + TYPE_W;
  localparam int IN_ALIGN_LSB = IN_SIZE_LSB + ADDR_W;
  localparam int IN_VIRT_LSB  = IN_ALIGN_LSB + ADDR_W;
  localparam int IN_TDATA_W   = IN_VIRT_LSB + ADDR_W;

  localparam int OUT_TDATA_W = 2 * ADDR_W;
  localparam int OUT_TUSER_W = 2;

  // Request opcodes carried on the input tuser.
  localparam logic [OPC_W-1:0] OP_MAP   = 2'd0;
  localparam logic [OPC_W-1:0] OP_ALLOC = 2'd1;
  localparam logic [OPC_W-1:0] OP_XLATE = 2'd2;
  localparam logic [OPC_W-1:0] OP_STOP  = 2'd3;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_DIRECT_MAP_OFFSET = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_REGION_BYTES  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_REGION_BASE   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_USABLE_TYPE_CODE  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_MODULE_TYPE_CODE  = 3'd4;

  // Configuration reset values.
  localparam logic [ADDR_W-1:0] MIN_REGION_BYTES_RST = 64'd16777216;
  localparam logic [ADDR_W-1:0] MIN_REGION_BASE_RST  = 64'h0000_0000_0010_0000;
  localparam logic [TYPE_W-1:0] USABLE_TYPE_RST      = 8'd0;
  localparam logic [TYPE_W-1:0] MODULE_TYPE_RST      = 8'd6;

  // Datapath operation selected by the controller for the current cycle.
  typedef enum logic [3:0] {
    STEP_NONE,
    STEP_AL1,
    STEP_AL2,
    STEP_AL3,
    STEP_AL4,
    STEP_AL5,
    STEP_XLATE,
    STEP_STOP,
    STEP_FOUND,
    STEP_NOTFOUND
  } dp_step_t;

  typedef struct packed {
    logic             capture;
    logic             load_clear;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic             cand_latch;
    logic             emit;
    dp_step_t         step;
  } ctl_cmd_t;

  typedef struct packed {
    logic is_cand;
    logic clash;
  } dp_status_t;

endpackage

`default_nettype wire

/* hdl/drba_datapath.sv */
`default_nettype none

module drba_datapath (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic [drba_pkg::IN_TDATA_W-1:0]   in_tdata,
  input  wire logic                              cfg_valid,
  input  wire logic [drba_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [drba_pkg::ADDR_W-1:0]       cfg_data,
  input  wire drba_pkg::ctl_cmd_t                cmd,
  output drba_pkg::dp_status_t                   status,
  output logic [drba_pkg::OUT_TDATA_W-1:0]       out_tdata,
  output logic [drba_pkg::OUT_TUSER_W-1:0]       out_tuser
);
  import drba_pkg::*;

  // Configuration registers.
  logic [ADDR_W-1:0] direct_map_offset;
  logic [ADDR_W-1:0] min_region_bytes;
  logic [ADDR_W-1:0] min_region_base;
  logic [TYPE_W-1:0] usable_type_code;
  logic [TYPE_W-1:0] module_type_code;

  // Region state.
  logic [ADDR_W-1:0] region_base;
  logic [ADDR_W-1:0] region_size;
  logic [ADDR_W-1:0] bump_offset;
  logic              ready;

  // Captured request.
  logic [ADDR_W-1:0] q_base;
  logic [ADDR_W-1:0] q_len;
  logic [TYPE_W-1:0] q_type;
  logic [ADDR_W-1:0] q_size;
  logic [ADDR_W-1:0] q_align;
  logic [ADDR_W-1:0] q_virt;

  // Memory-map table.
  logic [ADDR_W-1:0] mem_base [MAX_ENTRIES];
  logic [ADDR_W-1:0] mem_len  [MAX_ENTRIES];
  logic [TYPE_W-1:0] mem_type [MAX_ENTRIES];
  logic [ADDR_W-1:0] rd_base;
  logic [ADDR_W-1:0] rd_len;
  logic [TYPE_W-1:0] rd_type;

  // Scan candidate.
  logic [ADDR_W-1:0] cand_base;
  logic [ADDR_W-1:0] cand_len;
  logic [ADDR_W:0]   cand_limit;

  // Allocation scratch.
  logic [ADDR_W:0]   a_cur;
  logic [ADDR_W-1:0] a_mask;
  logic [ADDR_W-1:0] a_bd;
  logic [ADDR_W+1:0] a_t;
  logic [ADDR_W+1:0] a_n;
  logic [ADDR_W:0]   a_end;
  logic              a_nhi_bad;
  logic              alloc_ok;

  // Result and output word.
  logic [ADDR_W-1:0] res_addr;
  logic [ADDR_W-1:0] res_len;
  logic              res_ok;
  logic [ADDR_W-1:0] out_addr;
  logic [ADDR_W-1:0] out_len;
  logic              out_ok;
  logic              out_ready;

  always_comb begin
    status.is_cand = (rd_type == usable_type_code) && (rd_len >= min_region_bytes) &&
                     (rd_base >= min_region_base);
    // Exact-sum interval overlap against the latched candidate.
    status.clash   = (rd_type == module_type_code) &&
                     ({1'b0, cand_base} < ({1'b0, rd_base} + {1'b0, rd_len})) &&
                     ({1'b0, rd_base} < cand_limit);
    alloc_ok       = ready && (q_size != '0) && !a_nhi_bad &&
                     (a_end <= {1'b0, region_size});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      direct_map_offset <= '0;
      min_region_bytes  <= MIN_REGION_BYTES_RST;
      min_region_base   <= MIN_REGION_BASE_RST;
      usable_type_code  <= USABLE_TYPE_RST;
      module_type_code  <= MODULE_TYPE_RST;
      region_base       <= '0;
      region_size       <= '0;
      bump_offset       <= '0;
      ready             <= 1'b0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          CFG_DIRECT_MAP_OFFSET: direct_map_offset <= cfg_data;
          CFG_MIN_REGION_BYTES:  min_region_bytes  <= cfg_data;
          CFG_MIN_REGION_BASE:   min_region_base   <= cfg_data;
          CFG_USABLE_TYPE_CODE:  usable_type_code  <= cfg_data[TYPE_W-1:0];
          CFG_MODULE_TYPE_CODE:  module_type_code  <= cfg_data[TYPE_W-1:0];
          default: ;
        endcase
      end
      if (cmd.load_clear) begin
        region_base <= '0;
        region_size <= '0;
        bump_offset <= '0;
        ready       <= 1'b0;
      end
      case (cmd.step)
        STEP_FOUND: begin
          region_base <= cand_base;
          region_size <= cand_len;
          bump_offset <= '0;
          ready       <= 1'b1;
        end
        STEP_AL5: begin
          if (alloc_ok) begin
            bump_offset <= a_end[ADDR_W-1:0];
          end
        end
        STEP_STOP: ready <= 1'b0;
        default: ;
      endcase
    end
  end

  // Table write and registered read.
  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem_base[cmd.wr_addr] <= q_base;
      mem_len[cmd.wr_addr]  <= q_len;
      mem_type[cmd.wr_addr] <= q_type;
    end
    if (cmd.rd_en) begin
      rd_base <= mem_base[cmd.rd_addr];
      rd_len  <= mem_len[cmd.rd_addr];
      rd_type <= mem_type[cmd.rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      q_base  <= in_tdata[IN_BASE_LSB +: ADDR_W];
      q_len   <= in_tdata[IN_LEN_LSB +: ADDR_W];
      q_type  <= in_tdata[IN_TYPE_LSB +: TYPE_W];
      q_size  <= in_tdata[IN_SIZE_LSB +: ADDR_W];
      q_align <= in_tdata[IN_ALIGN_LSB +: ADDR_W];
      q_virt  <= in_tdata[IN_VIRT_LSB +: ADDR_W];
    end
    if (cmd.cand_latch) begin
      cand_base  <= rd_base;
      cand_len   <= rd_len;
      cand_limit <= {1'b0, rd_base} + {1'b0, rd_len};
    end
    case (cmd.step)
      STEP_AL1: begin
        a_cur  <= {1'b0, region_base} + {1'b0, bump_offset};
        a_mask <= (q_align == '0) ? '0 : q_align - 64'd1;
        a_bd   <= region_base + direct_map_offset;
      end
      STEP_AL2: a_t <= ({1'b0, a_cur} + {2'b00, a_mask}) & ~{2'b00, a_mask};
      STEP_AL3: a_n <= a_t - {2'b00, region_base};
      STEP_AL4: begin
        a_end     <= {1'b0, a_n[ADDR_W-1:0]} + {1'b0, q_size};
        a_nhi_bad <= (a_n[ADDR_W+1:ADDR_W] != 2'b00);
      end
      STEP_AL5: begin
        res_addr <= alloc_ok ? a_bd + a_n[ADDR_W-1:0] : '0;
        res_len  <= '0;
        res_ok   <= alloc_ok;
      end
      STEP_XLATE: begin
        if (q_virt == '0) begin
          res_addr <= '0;
        end else if (q_virt >= direct_map_offset) begin
          res_addr <= q_virt - direct_map_offset;
        end else begin
          res_addr <= q_virt;
        end
        res_len <= '0;
        res_ok  <= (q_virt != '0);
      end
      STEP_STOP: begin
        res_addr <= '0;
        res_len  <= '0;
        res_ok   <= 1'b1;
      end
      STEP_FOUND: begin
        res_addr <= cand_base;
        res_len  <= cand_len;
        res_ok   <= 1'b1;
      end
      STEP_NOTFOUND: begin
        res_addr <= '0;
        res_len  <= '0;
        res_ok   <= 1'b0;
      end
      default: ;
    endcase
    if (cmd.emit) begin
      out_addr  <= res_addr;
      out_len   <= res_len;
      out_ok    <= res_ok;
      out_ready <= ready;
    end
  end

  assign out_tdata = {out_len, out_addr};
  assign out_tuser = {out_ready, out_ok};

endmodule

`default_nettype wire

/* hdl/drba_ctrl.sv */
`default_nettype none

module drba_ctrl (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_tvalid,
  output logic                               in_tready,
  input  wire logic [drba_pkg::OPC_W-1:0]    in_tuser,
  input  wire logic                          in_tlast,
  output logic                               out_tvalid,
  input  wire logic                          out_tready,
  input  wire drba_pkg::dp_status_t          status,
  output drba_pkg::ctl_cmd_t                 cmd
);
  import drba_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MAP,
    S_AL1,
    S_AL2,
    S_AL3,
    S_AL4,
    S_AL5,
    S_XLATE,
    S_STOP,
    S_SC_I_RD,
    S_SC_I_CHK,
    S_SC_J_RD,
    S_SC_J_CHK,
    S_EMIT
  } state_t;

  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_ENTRIES);

  state_t           state, state_next;
  logic             out_valid, out_valid_next;
  logic             loading, loading_next;
  logic             last_q, last_q_next;
  logic [CNT_W-1:0] map_count, map_count_next;
  logic [CNT_W-1:0] scan_i, scan_i_next;
  logic [CNT_W-1:0] scan_j, scan_j_next;
  logic [CNT_W-1:0] cnt_eff;

  always_comb begin
    state_next     = state;
    out_valid_next = out_valid && !out_tready;
    loading_next   = loading;
    last_q_next    = last_q;
    map_count_next = map_count;
    scan_i_next    = scan_i;
    scan_j_next    = scan_j;
    cmd            = '0;
    cmd.step       = STEP_NONE;
    // A fresh load starts counting from zero.
    cnt_eff        = loading ? map_count : '0;

    unique case (state)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.capture = 1'b1;
          last_q_next = in_tlast;
          unique case (in_tuser)
            OP_MAP:   state_next = S_MAP;
            OP_ALLOC: state_next = S_AL1;
            OP_XLATE: state_next = S_XLATE;
            OP_STOP:  state_next = S_STOP;
            default:  state_next = S_IDLE;
          endcase
        end
      end
      S_MAP: begin
        cmd.load_clear = !loading;
        map_count_next = cnt_eff;
        if (cnt_eff < MAX_CNT) begin
          cmd.wr_en      = 1'b1;
          cmd.wr_addr    = cnt_eff[IDX_W-1:0];
          map_count_next = cnt_eff + 1'b1;
        end
        if (last_q) begin
          loading_next = 1'b0;
          scan_i_next  = '0;
          state_next   = S_SC_I_RD;
        end else begin
          loading_next = 1'b1;
          state_next   = S_IDLE;
        end
      end
      S_AL1: begin
        cmd.step   = STEP_AL1;
        state_next = S_AL2;
      end
      S_AL2: begin
        cmd.step   = STEP_AL2;
        state_next = S_AL3;
      end
      S_AL3: begin
        cmd.step   = STEP_AL3;
        state_next = S_AL4;
      end
      S_AL4: begin
        cmd.step   = STEP_AL4;
        state_next = S_AL5;
      end
      S_AL5: begin
        cmd.step   = STEP_AL5;
        state_next = S_EMIT;
      end
      S_XLATE: begin
        cmd.step   = STEP_XLATE;
        state_next = S_EMIT;
      end
      S_STOP: begin
        cmd.step   = STEP_STOP;
        state_next = S_EMIT;
      end
      S_SC_I_RD: begin
        if (scan_i >= map_count) begin
          cmd.step   = STEP_NOTFOUND;
          state_next = S_EMIT;
        end else begin
          cmd.rd_en   = 1'b1;
          cmd.rd_addr = scan_i[IDX_W-1:0];
          state_next  = S_SC_I_CHK;
        end
      end
      S_SC_I_CHK: begin
        cmd.cand_latch = 1'b1;
        if (status.is_cand) begin
          scan_j_next = '0;
          state_next  = S_SC_J_RD;
        end else begin
          scan_i_next = scan_i + 1'b1;
          state_next  = S_SC_I_RD;
        end
      end
      S_SC_J_RD: begin
        if (scan_j >= map_count) begin
          cmd.step   = STEP_FOUND;
          state_next = S_EMIT;
        end else begin
          cmd.rd_en   = 1'b1;
          cmd.rd_addr = scan_j[IDX_W-1:0];
          state_next  = S_SC_J_CHK;
        end
      end
      S_SC_J_CHK: begin
        if (status.clash) begin
          scan_i_next = scan_i + 1'b1;
          state_next  = S_SC_I_RD;
        end else begin
          scan_j_next = scan_j + 1'b1;
          state_next  = S_SC_J_RD;
        end
      end
      S_EMIT: begin
        if (!out_valid || out_tready) begin
          cmd.emit       = 1'b1;
          out_valid_next = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      loading   <= 1'b0;
      last_q    <= 1'b0;
      map_count <= '0;
      scan_i    <= '0;
      scan_j    <= '0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
      loading   <= loading_next;
      last_q    <= last_q_next;
      map_count <= map_count_next;
      scan_i    <= scan_i_next;
      scan_j    <= scan_j_next;
    end
  end

  assign in_tready  = (state == S_IDLE);
  assign out_tvalid = out_valid;

endmodule

`default_nettype wire

/* hdl/dma_region_bump_allocator_unit.sv */
// DMA region bump allocator.
// Requests arrive on the s_axis channel, one word each; tuser holds the opcode (map entry,
// allocate, translate, stop) and tlast marks the final entry of a memory map. Results leave
// on the m_axis channel: tdata carries the address and region length, tuser the success
// and region-ready flags. Configuration registers are written over the cfg channel, which
// is always ready and must only be used while the block is idle.
// The block handles one request at a time. A map entry that is not the last is stored
// in the table and gives no result. Translate and stop compute their result and hand it
// to the output register; an allocation first runs a five-step add/align/compare sequence.
// The last map entry starts a scan of the stored table through its single read port:
// each stored entry in turn is read and checked as an outer candidate, and a qualifying one
// is then checked against every stored entry until one clashes with it or none is left.
// The result sits in an output register; a new request is accepted as soon as the
// previous one has been handed to that register, even if the receiver stalls. When the
// output word is still held, the next result waits until it is taken.
// Synchronous reset returns the controller to idle, empties the output register, restores
// the configuration defaults and clears the region (not ready). Table contents are not
// cleared; only entries written in the current load are ever read.
`default_nettype none

module dma_region_bump_allocator_unit (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              s_axis_tvalid,
  output logic                                   s_axis_tready,
  // Fields from bit 0: entry_base, entry_length, entry_type, request_size,
  // request_align, virt_addr.
  input  wire logic [drba_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
  // Fields from bit 0: opcode.
  input  wire logic [drba_pkg::OPC_W-1:0]        s_axis_tuser,
  input  wire logic                              s_axis_tlast,
  output logic                                   m_axis_tvalid,
  input  wire logic                              m_axis_tready,
  // Fields from bit 0: result_address, result_length.
  output logic [drba_pkg::OUT_TDATA_W-1:0]       m_axis_tdata,
  // Fields from bit 0: success, region_ready.
  output logic [drba_pkg::OUT_TUSER_W-1:0]       m_axis_tuser,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [drba_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [drba_pkg::ADDR_W-1:0]       cfg_data
);
  import drba_pkg::*;

  ctl_cmd_t   cmd;
  dp_status_t status;

  // Configuration writes never stall.
  assign cfg_ready = 1'b1;

  drba_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_tvalid  (s_axis_tvalid),
    .in_tready  (s_axis_tready),
    .in_tuser   (s_axis_tuser),
    .in_tlast   (s_axis_tlast),
    .out_tvalid (m_axis_tvalid),
    .out_tready (m_axis_tready),
    .status     (status),
    .cmd        (cmd)
  );

  drba_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .in_tdata  (s_axis_tdata),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .status    (status),
    .out_tdata (m_axis_tdata),
    .out_tuser (m_axis_tuser)
  );

  // The output register is only loaded when it is empty or being drained.
  a_emit_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> (!m_axis_tvalid || m_axis_tready))
    else $error("result word loaded over an untaken word");

  // One request at a time: an accepted word is followed by a busy cycle.
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("request accepted while the previous one was in progress");

  // Table writes and scan reads never happen while a request can be accepted.
  a_table_busy: assert property (@(posedge clk) disable iff (rst)
    (cmd.wr_en || cmd.rd_en) |-> (!s_axis_tready && !(cmd.wr_en && cmd.rd_en)))
    else $error("table access outside the busy phase");

endmodule

`default_nettype wire

/* bench/drba_checker.sv */
`timescale 1ns / 100ps

// Watches the request, result and configuration channels of the DMA region allocator.
// It predicts every result word from the accepted requests and compares it with what
// the block hands out.
module drba_checker (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              s_axis_tvalid,
  input  wire logic                              s_axis_tready,
  input  wire logic [drba_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
  input  wire logic [drba_pkg::OPC_W-1:0]        s_axis_tuser,
  input  wire logic                              s_axis_tlast,
  input  wire logic                              m_axis_tvalid,
  input  wire logic                              m_axis_tready,
  input  wire logic [drba_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
  input  wire logic [drba_pkg::OUT_TUSER_W-1:0]  m_axis_tuser,
  input  wire logic                              cfg_valid,
  input  wire logic                              cfg_ready,
  input  wire logic [drba_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [drba_pkg::ADDR_W-1:0]       cfg_data,
  output int                                     errors,
  output int                                     pending
);
  import drba_pkg::*;

  typedef struct packed {
    logic [ADDR_W-1:0] address;
    logic [ADDR_W-1:0] length;
    logic              success;
    logic              region_ready;
  } alloc_result_t;

  alloc_result_t awaited_results[$];
  alloc_result_t want;

  // Memory-map table and region state as the block should hold them.
  logic [ADDR_W-1:0] tbl_base [MAX_ENTRIES];
  logic [ADDR_W-1:0] tbl_len  [MAX_ENTRIES];
  logic [TYPE_W-1:0] tbl_type [MAX_ENTRIES];
  int                tbl_count;
  logic              loading;
  logic [ADDR_W-1:0] region_base;
  logic [ADDR_W-1:0] region_size;
  logic [ADDR_W-1:0] bump_offset;
  logic              ready;

  logic [ADDR_W-1:0] direct_map_offset;
  logic [ADDR_W-1:0] min_region_bytes;
  logic [ADDR_W-1:0] min_region_base;
  logic [TYPE_W-1:0] usable_code;
  logic [TYPE_W-1:0] avoid_code;

  initial begin
    errors  = 0;
    pending = 0;
  end

  // x < b + len with the sum taken one bit wider, so it never wraps.
  function automatic logic below_end(logic [ADDR_W-1:0] x, logic [ADDR_W-1:0] b,
                                     logic [ADDR_W-1:0] len);
    return {1'b0, x} < ({1'b0, b} + {1'b0, len});
  endfunction

  function automatic logic spans_overlap(logic [ADDR_W-1:0] a, logic [ADDR_W-1:0] la,
                                         logic [ADDR_W-1:0] b, logic [ADDR_W-1:0] lb);
    return below_end(a, b, lb) && below_end(b, a, la);
  endfunction

  // First usable, large enough, high enough entry that clears every module entry.
  function automatic logic choose_region();
    int   i;
    int   j;
    logic clash;
    for (i = 0; i < tbl_count; i++) begin
      if (tbl_type[i] == usable_code && tbl_len[i] >= min_region_bytes &&
          tbl_base[i] >= min_region_base) begin
        clash = 1'b0;
        for (j = 0; j < tbl_count && !clash; j++)
          if (tbl_type[j] == avoid_code &&
              spans_overlap(tbl_base[i], tbl_len[i], tbl_base[j], tbl_len[j]))
            clash = 1'b1;
        if (!clash) begin
          region_base = tbl_base[i];
          region_size = tbl_len[i];
          bump_offset = '0;
          ready       = 1'b1;
          return 1'b1;
        end
      end
    end
    return 1'b0;
  endfunction

  function automatic logic bump_alloc(input logic [ADDR_W-1:0] size,
                                      input logic [ADDR_W-1:0] align,
                                      output logic [ADDR_W-1:0] addr);
    logic [ADDR_W-1:0] mask;
    logic [ADDR_W+1:0] cursor;
    logic [ADDR_W+1:0] offset;
    logic [ADDR_W:0]   end_off;
    addr = '0;
    mask = (align == '0) ? '0 : align - 1'b1;
    if (!ready || size == '0)
      return 1'b0;
    // The cursor keeps its carries above bit 63; only the low bits are masked.
    cursor = {2'b00, region_base} + {2'b00, bump_offset} + {2'b00, mask};
    cursor[ADDR_W-1:0] = cursor[ADDR_W-1:0] & ~mask;
    offset = cursor - {2'b00, region_base};
    if (offset[ADDR_W+1:ADDR_W] != 2'b00)
      return 1'b0;
    end_off = {1'b0, offset[ADDR_W-1:0]} + {1'b0, size};
    if (end_off > {1'b0, region_size})
      return 1'b0;
    bump_offset = end_off[ADDR_W-1:0];
    addr = region_base + direct_map_offset + offset[ADDR_W-1:0];
    return 1'b1;
  endfunction

  task automatic serve_request(input logic [OPC_W-1:0] op, input logic [IN_TDATA_W-1:0] data,
                               input logic last);
    alloc_result_t     res;
    logic [ADDR_W-1:0] virt;
    logic [ADDR_W-1:0] addr;
    res  = '0;
    virt = data[IN_VIRT_LSB +: ADDR_W];
    case (op)
      OP_MAP: begin
        // The first entry after an idle period opens a new load.
        if (!loading) begin
          loading     = 1'b1;
          tbl_count   = 0;
          region_base = '0;
          region_size = '0;
          bump_offset = '0;
          ready       = 1'b0;
        end
        if (tbl_count < MAX_ENTRIES) begin
          tbl_base[tbl_count] = data[IN_BASE_LSB +: ADDR_W];
          tbl_len[tbl_count]  = data[IN_LEN_LSB +: ADDR_W];
          tbl_type[tbl_count] = data[IN_TYPE_LSB +: TYPE_W];
          tbl_count++;
        end
        if (last) begin
          loading     = 1'b0;
          res.success = choose_region();
          res.address = region_base;
          res.length  = region_size;
        end
      end
      OP_ALLOC: begin
        res.success = bump_alloc(data[IN_SIZE_LSB +: ADDR_W], data[IN_ALIGN_LSB +: ADDR_W],
                                 addr);
        res.address = addr;
      end
      OP_XLATE: begin
        if (virt != '0) begin
          res.address = (virt >= direct_map_offset) ? virt - direct_map_offset : virt;
          res.success = 1'b1;
        end
      end
      OP_STOP: begin
        ready       = 1'b0;
        res.success = 1'b1;
      end
    endcase
    if (op != OP_MAP || last) begin
      res.region_ready = ready;
      awaited_results.push_back(res);
    end
  endtask

  task automatic check_field(input string name, input logic [ADDR_W-1:0] expected_val,
                             input logic [ADDR_W-1:0] actual_val);
    if (actual_val !== expected_val) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, expected_val, actual_val);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      tbl_count         = 0;
      loading           = 1'b0;
      region_base       = '0;
      region_size       = '0;
      bump_offset       = '0;
      ready             = 1'b0;
      direct_map_offset = '0;
      min_region_bytes  = MIN_REGION_BYTES_RST;
      min_region_base   = MIN_REGION_BASE_RST;
      usable_code       = USABLE_TYPE_RST;
      avoid_code        = MODULE_TYPE_RST;
      awaited_results.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_DIRECT_MAP_OFFSET: direct_map_offset = cfg_data;
          CFG_MIN_REGION_BYTES:  min_region_bytes  = cfg_data;
          CFG_MIN_REGION_BASE:   min_region_base   = cfg_data;
          CFG_USABLE_TYPE_CODE:  usable_code       = cfg_data[TYPE_W-1:0];
          CFG_MODULE_TYPE_CODE:  avoid_code        = cfg_data[TYPE_W-1:0];
          default: ;
        endcase
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (awaited_results.size() == 0) begin
          $error("result word with nothing expected: address 0x%0h",
                 m_axis_tdata[ADDR_W-1:0]);
          errors++;
        end else begin
          want = awaited_results.pop_front();
          check_field("result_address", want.address, m_axis_tdata[ADDR_W-1:0]);
          check_field("result_length", want.length, m_axis_tdata[2*ADDR_W-1:ADDR_W]);
          check_field("success", {{(ADDR_W-1){1'b0}}, want.success},
                      {{(ADDR_W-1){1'b0}}, m_axis_tuser[0]});
          check_field("region_ready", {{(ADDR_W-1){1'b0}}, want.region_ready},
                      {{(ADDR_W-1){1'b0}}, m_axis_tuser[1]});
        end
      end
      if (s_axis_tvalid && s_axis_tready)
        serve_request(s_axis_tuser, s_axis_tdata, s_axis_tlast);
    end
    pending = awaited_results.size();
  end

endmodule

/* bench/tb_dma_region_bump_allocator_unit.sv */
`timescale 1ns / 100ps

module tb_dma_region_bump_allocator_unit;
  import drba_pkg::*;

  // Generous bound on the whole run; the slowest legal run stays far below it.
  localparam int CYCLE_LIMIT   = 1000000;
  // Cycles left after the last awaited word before the block counts as idle.
  localparam int SETTLE_CYCLES = 20;
  // Length of the long receiver hold-off that backs the block up.
  localparam int HOLD_CYCLES   = 400;
  localparam logic [ADDR_W-1:0] ONES = '1;

  logic                   clk           = 1'b0;
  logic                   rst           = 1'b1;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  // Fields from bit 0: entry_base, entry_length, entry_type, request_size,
  // request_align, virt_addr.
  logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
  // Fields from bit 0: opcode.
  logic [OPC_W-1:0]       s_axis_tuser  = OP_MAP;
  logic                   s_axis_tlast  = 1'b0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  // Fields from bit 0: result_address, result_length.
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  // Fields from bit 0: success, region_ready.
  logic [OUT_TUSER_W-1:0] m_axis_tuser;
  logic                   cfg_valid     = 1'b0;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index     = CFG_DIRECT_MAP_OFFSET;
  logic [ADDR_W-1:0]      cfg_data      = '0;

  int errors;
  int pending;

  // Request words accepted so far, and the cycle count for the watchdog.
  int sent          = 0;
  int cycles        = 0;
  // Percent chances that the sender idles or the receiver stalls in a cycle.
  int send_idle_pct = 0;
  int stall_pct     = 0;
  logic hold_req    = 1'b0;

  // Current settings, kept here only to steer the memory maps toward interesting cases.
  logic [ADDR_W-1:0] map_dmo        = '0;
  logic [ADDR_W-1:0] map_min_bytes  = MIN_REGION_BYTES_RST;
  logic [ADDR_W-1:0] map_base_floor = MIN_REGION_BASE_RST;
  logic [TYPE_W-1:0] map_usable     = USABLE_TYPE_RST;
  logic [TYPE_W-1:0] map_avoid      = MODULE_TYPE_RST;
  logic [ADDR_W-1:0] last_base      = MIN_REGION_BASE_RST;

  dma_region_bump_allocator_unit dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  // The checker sees every handshake on all three channels and owns the verdict data.
  drba_checker u_checker (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .errors        (errors),
    .pending       (pending)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Watchdog: a hung handshake or a lost result word ends the run here.
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Result side. It stalls at random at the current rate, and once, when asked, it
  // holds off for a long stretch that it counts itself.
  initial begin : result_sink
    int   hold_left;
    logic hold_taken;
    hold_left  = 0;
    hold_taken = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !hold_taken) begin
        hold_taken = 1'b1;
        hold_left  = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        m_axis_tready <= 1'b0;
        hold_left--;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // A 64-bit value that lands on the edges often: zero, all ones, single bits and
  // their complements, small numbers, or anything at all.
  function automatic logic [ADDR_W-1:0] pick_word();
    case ($urandom_range(7))
      0: return '0;
      1: return ONES;
      2: return 64'd1 << $urandom_range(63);
      3: return {32'd0, $urandom_range(4096)};
      4: return ~(64'd1 << $urandom_range(63));
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic logic [ADDR_W-1:0] pick_align();
    case ($urandom_range(9))
      0: return '0;
      1: return ONES;
      2: return {32'd0, $urandom_range(100, 1)};
      3: return 64'd1 << $urandom_range(63);
      default: return 64'd1 << $urandom_range(12);
    endcase
  endfunction

  // Mostly small sizes so that a region serves many allocations before it fills.
  function automatic logic [ADDR_W-1:0] pick_size();
    case ($urandom_range(9))
      0: return '0;
      1: return pick_word();
      2: return map_min_bytes >> $urandom_range(4);
      default: return {32'd0, $urandom_range(65536, 1)};
    endcase
  endfunction

  function automatic logic [ADDR_W-1:0] pick_virt();
    case ($urandom_range(7))
      0: return '0;
      1: return map_dmo;
      2: return map_dmo - 1'b1;
      3: return map_dmo + {32'd0, $urandom};
      default: return pick_word();
    endcase
  endfunction

  // Bases and lengths cluster around the current minimums so that the scan has real
  // choices to make, with the values just below them and wild ones mixed in.
  function automatic logic [ADDR_W-1:0] pick_entry_base();
    case ($urandom_range(5))
      3: return pick_word();
      4: return map_base_floor - 1'b1;
      default: return map_base_floor + ({32'd0, $urandom_range(4095)} << 20);
    endcase
  endfunction

  function automatic logic [ADDR_W-1:0] pick_entry_len();
    case ($urandom_range(5))
      3: return pick_word();
      4: return map_min_bytes - 1'b1;
      5: return map_min_bytes;
      default: return map_min_bytes + ({32'd0, $urandom_range(4095)} << 16);
    endcase
  endfunction

  function automatic logic [TYPE_W-1:0] pick_entry_type();
    case ($urandom_range(9))
      5, 6:    return map_avoid;
      7, 8:    return TYPE_W'($urandom_range(255));
      default: return map_usable;
    endcase
  endfunction

  // Offers one request word and returns at the edge where it is taken. The valid
  // stays high when the next word follows at once.
  task automatic send_req(input logic [OPC_W-1:0] op, input logic [ADDR_W-1:0] base,
                          input logic [ADDR_W-1:0] len, input logic [TYPE_W-1:0] etype,
                          input logic last, input logic [ADDR_W-1:0] size,
                          input logic [ADDR_W-1:0] align, input logic [ADDR_W-1:0] virt);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tlast  <= last;
    s_axis_tdata  <= {virt, align, size, etype, len, base};
    @(posedge clk);
    while (!s_axis_tready)
      @(posedge clk);
    sent++;
  endtask

  // Fields an operation does not use still carry random values.
  task automatic send_entry(input logic [ADDR_W-1:0] base, input logic [ADDR_W-1:0] len,
                            input logic [TYPE_W-1:0] etype, input logic last);
    send_req(OP_MAP, base, len, etype, last, pick_word(), pick_word(), pick_word());
  endtask

  task automatic send_alloc(input logic [ADDR_W-1:0] size, input logic [ADDR_W-1:0] align);
    send_req(OP_ALLOC, pick_word(), pick_word(), TYPE_W'($urandom_range(255)),
             1'($urandom_range(1)), size, align, pick_word());
  endtask

  task automatic send_xlate(input logic [ADDR_W-1:0] virt);
    send_req(OP_XLATE, pick_word(), pick_word(), TYPE_W'($urandom_range(255)),
             1'($urandom_range(1)), pick_word(), pick_word(), virt);
  endtask

  task automatic send_stop();
    send_req(OP_STOP, pick_word(), pick_word(), TYPE_W'($urandom_range(255)),
             1'($urandom_range(1)), pick_word(), pick_word(), pick_word());
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [ADDR_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready)
      @(posedge clk);
  endtask

  // Writes all five registers back to back; only called while the block is idle.
  task automatic set_config(input logic [ADDR_W-1:0] dmo, input logic [ADDR_W-1:0] min_bytes,
                            input logic [ADDR_W-1:0] base_floor,
                            input logic [TYPE_W-1:0] usable,
                            input logic [TYPE_W-1:0] avoid);
    cfg_write(CFG_DIRECT_MAP_OFFSET, dmo);
    cfg_write(CFG_MIN_REGION_BYTES, min_bytes);
    cfg_write(CFG_MIN_REGION_BASE, base_floor);
    cfg_write(CFG_USABLE_TYPE_CODE, {56'd0, usable});
    cfg_write(CFG_MODULE_TYPE_CODE, {56'd0, avoid});
    cfg_valid      <= 1'b0;
    map_dmo        = dmo;
    map_min_bytes  = min_bytes;
    map_base_floor = base_floor;
    map_usable     = usable;
    map_avoid      = avoid;
    last_base      = base_floor;
  endtask

  // Drops the valid, waits for every awaited word, then lets a map entry that gives
  // no word finish its own work. The count is sampled on the falling edge so that
  // the checker has settled for the cycle.
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    @(negedge clk);
    while (pending != 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // A memory map of n entries, the last marked if close_map is set. Module entries often
  // sit just above the latest ordinary base to cut into candidates; some are empty.
  task automatic load_map(input int n, input logic close_map);
    int                k;
    logic [TYPE_W-1:0] etype;
    logic [ADDR_W-1:0] base;
    logic [ADDR_W-1:0] len;
    for (k = 0; k < n; k++) begin
      etype = pick_entry_type();
      if (etype == map_avoid && etype != map_usable && $urandom_range(1) == 1) begin
        base = last_base + ({32'd0, $urandom_range(32'hFFFF)} << 10);
        len  = {32'd0, $urandom_range(32'h0020_0000)};
      end else begin
        base = pick_entry_base();
        len  = pick_entry_len();
        last_base = base;
      end
      send_entry(base, len, etype, close_map && (k == n - 1));
    end
  endtask

  task automatic run_requests(input int n);
    int k;
    int pick;
    for (k = 0; k < n; k++) begin
      pick = $urandom_range(99);
      if (pick < 62)
        send_alloc(pick_size(), pick_align());
      else if (pick < 92)
        send_xlate(pick_virt());
      else
        send_stop();
    end
  endtask

  // Mostly complete loads followed by requests on the fresh region; the rest is
  // random words of any kind and loads broken off before their last entry. Now and
  // then a load runs past the table capacity.
  task automatic random_phase(input int goal);
    int stop_at;
    int kind;
    int n;
    stop_at = sent + goal;
    while (sent < stop_at) begin
      kind = $urandom_range(99);
      if (kind < 70) begin
        n = ($urandom_range(11) == 0) ? $urandom_range(70, 64) : $urandom_range(8, 1);
        load_map(n, 1'b1);
        run_requests($urandom_range(12, 3));
      end else if (kind < 85) begin
        send_req(OPC_W'($urandom_range(3)), pick_word(), pick_word(),
                 TYPE_W'($urandom_range(255)), 1'($urandom_range(1)), pick_word(),
                 pick_word(), pick_word());
      end else begin
        load_map($urandom_range(4, 1), 1'b0);
        run_requests($urandom_range(4, 1));
      end
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part under the reset settings. Nothing is ready yet, so the first
    // allocation must fail; translation of address zero fails as well.
    send_alloc(64'd64, 64'd0);
    send_xlate(64'd0);
    send_xlate(ONES);
    send_stop();
    // A module entry cuts into the first usable candidate; the next one lies below the
    // minimum base, the one after is one byte too short, and the last one fits.
    send_entry(64'h0200_0000, 64'h1000, 8'd6, 1'b0);
    send_entry(64'h0100_0000, 64'h0400_0000, 8'd0, 1'b0);
    send_entry(64'h0, 64'h0200_0000, 8'd0, 1'b0);
    send_entry(64'h2000_0000, 64'h00FF_FFFF, 8'd0, 1'b0);
    send_entry(64'h4000_0000, 64'h0100_0000, 8'd0, 1'b1);
    // Zero size, zero alignment, a page alignment, an odd alignment, a huge alignment,
    // a size that cannot fit and an all-ones alignment.
    send_alloc(64'd0, 64'd8);
    send_alloc(64'd1, 64'd0);
    send_alloc(64'd100, 64'd4096);
    send_alloc(64'd10, 64'd3);
    send_alloc(64'd1, 64'd1 << 63);
    send_alloc(ONES, 64'd1);
    send_alloc(64'd16, ONES);
    // Stop drops the ready flag, after which allocations fail.
    send_stop();
    send_alloc(64'd8, 64'd8);
    // A region at the very top of the address space, beside an empty module entry.
    // Its end lies beyond 2^64, and aligning the cursor carries past bit 63.
    send_entry(ONES, ONES, 8'd0, 1'b0);
    send_entry(64'h1000, 64'h0, 8'd6, 1'b1);
    send_alloc(64'h10, 64'h10);
    send_alloc(64'd1, 64'd0);
    send_xlate(64'h1234);
    // A single entry of the wrong type: no region.
    send_entry(64'h0020_0000, 64'h0200_0000, 8'd3, 1'b1);
    wait_idle();

    // Extreme settings: the offset at its top, no minimums, the type codes at both ends.
    set_config(ONES, '0, '0, 8'hFF, 8'h00);
    send_idle_pct = 51;
    stall_pct     = 0;
    random_phase(280);
    wait_idle();

    set_config(64'hFFFF_8000_0000_0000, 64'h1000, 64'h0010_0000, 8'h01, 8'h02);
    send_idle_pct = 0;
    stall_pct     = 51;
    random_phase(280);
    wait_idle();

    // Both minimums at their top: only an entry at the very end of memory qualifies.
    set_config(pick_word(), ONES, ONES, 8'h80, 8'h7F);
    send_idle_pct = 26;
    stall_pct     = 26;
    random_phase(200);
    wait_idle();

    // Equal usable and module codes: every nonempty candidate collides with itself.
    set_config({$urandom, $urandom}, 64'h1000, 64'h0, 8'h5A, 8'h5A);
    random_phase(100);
    wait_idle();

    // Back to the reset values for the minimums and codes. The receiver holds off for
    // a long time while the sender keeps offering words, so the block backs up.
    set_config(64'h0000_7FFF_0000_0000, MIN_REGION_BYTES_RST, MIN_REGION_BASE_RST,
               USABLE_TYPE_RST, MODULE_TYPE_RST);
    send_idle_pct = 0;
    stall_pct     = 0;
    hold_req <= 1'b1;
    repeat (40) send_xlate(pick_virt());
    random_phase(280);
    wait_idle();

    if (errors == 0 && pending == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule

/* filelist.f */
hdl/drba_pkg.sv
hdl/drba_datapath.sv
hdl/drba_ctrl.sv
hdl/dma_region_bump_allocator_unit.sv
bench/drba_checker.sv
bench/tb_dma_region_bump_allocator_unit.sv
